/* hw/rtl/dpx_pkg.sv */
// ----------------------------------------------------------------------------
// Data-processing execute package
// Types, operation codes, condition codes and flag positions shared by the
// execute stage, its shifter and its ALU.
// ----------------------------------------------------------------------------
package dpx_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned ActionW = 5;
  localparam int unsigned CondW   = 4;
  localparam int unsigned ShiftW  = 2;
  localparam int unsigned AmountW = 8;
  localparam int unsigned FlagsW  = 4;

  // Flag positions inside NZCV
  localparam int unsigned FLAG_N = 3;
  localparam int unsigned FLAG_Z = 2;
  localparam int unsigned FLAG_C = 1;
  localparam int unsigned FLAG_V = 0;

  typedef enum logic [ActionW-1:0] {
    ACT_MOV = 5'd0,
    ACT_MVN = 5'd1,
    ACT_AND = 5'd2,
    ACT_EOR = 5'd3,
    ACT_ORR = 5'd4,
    ACT_BIC = 5'd5,
    ACT_TST = 5'd6,
    ACT_TEQ = 5'd7,
    ACT_ADD = 5'd8,
    ACT_CMN = 5'd9,
    ACT_ADC = 5'd10,
    ACT_SUB = 5'd11,
    ACT_RSB = 5'd12,
    ACT_SBC = 5'd13,
    ACT_RSC = 5'd14,
    ACT_CMP = 5'd15,
    ACT_MUL = 5'd16,
    ACT_MLA = 5'd17
  } action_t;

  typedef enum logic [CondW-1:0] {
    COND_EQ = 4'd0,
    COND_NE = 4'd1,
    COND_CS = 4'd2,
    COND_CC = 4'd3,
    COND_MI = 4'd4,
    COND_PL = 4'd5,
    COND_VS = 4'd6,
    COND_VC = 4'd7,
    COND_HI = 4'd8,
    COND_LS = 4'd9,
    COND_GE = 4'd10,
    COND_LT = 4'd11,
    COND_GT = 4'd12,
    COND_LE = 4'd13,
    COND_AL = 4'd14,
    COND_NV = 4'd15
  } cond_t;

  typedef enum logic [ShiftW-1:0] {
    SHIFT_LSL = 2'd0,
    SHIFT_LSR = 2'd1,
    SHIFT_ASR = 2'd2,
    SHIFT_ROR = 2'd3
  } shift_t;

  // One decoded instruction with its operand values
  typedef struct packed {
    logic [ActionW-1:0] action;
    logic [CondW-1:0]   cond;
    logic               set_cc;
    logic [DataW-1:0]   first_operand;
    logic [DataW-1:0]   second_operand;
    logic               is_immediate;
    logic               imm_rotated;
    logic [ShiftW-1:0]  shift_op;
    logic [AmountW-1:0] shift_cnt;
    logic               shift_by_register;
    logic [DataW-1:0]   multiplier;
    logic               align_first;
  } dpx_item_t;

  // One execution result
  typedef struct packed {
    logic              executed;
    logic              write_result;
    logic [DataW-1:0]  result_value;
    logic [FlagsW-1:0] flags_after;
  } dpx_result_t;

  // Shifter output toward the ALU
  typedef struct packed {
    logic [DataW-1:0] value;
    logic             carry;
    logic             has_carry;
  } dpx_shift_t;

endpackage

/* hw/rtl/dpx_if.sv */
// ----------------------------------------------------------------------------
// Data-processing execute channels
// Valid/ready channels for instructions in and results out.
// ----------------------------------------------------------------------------
interface dpx_in_if import dpx_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ActionW-1:0] action;
  logic [CondW-1:0]   cond;
  logic               set_cc;
  logic [DataW-1:0]   first_operand;
  logic [DataW-1:0]   second_operand;
  logic               is_immediate;
  logic               imm_rotated;
  logic [ShiftW-1:0]  shift_op;
  logic [AmountW-1:0] shift_cnt;
  logic               shift_by_register;
  logic [DataW-1:0]   multiplier;
  logic               align_first;

  modport source (
    output valid, action, cond, set_cc, first_operand, second_operand,
           is_immediate, imm_rotated, shift_op, shift_cnt,
           shift_by_register, multiplier, align_first,
    input  ready
  );

  modport sink (
    input  valid, action, cond, set_cc, first_operand, second_operand,
           is_immediate, imm_rotated, shift_op, shift_cnt,
           shift_by_register, multiplier, align_first,
    output ready
  );
endinterface

interface dpx_out_if import dpx_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              executed;
  logic              write_result;
  logic [DataW-1:0]  result_value;
  logic [FlagsW-1:0] flags_after;

  modport source (
    output valid, executed, write_result, result_value, flags_after,
    input  ready
  );

  modport sink (
    input  valid, executed, write_result, result_value, flags_after,
    output ready
  );
endinterface

/* hw/rtl/dpx_shifter.sv */
// ----------------------------------------------------------------------------
// Barrel shifter
// LSL, LSR, ASR and ROR with the zero-amount encodings (LSR/ASR #32, RRX)
// and register amounts up to 255; reports the shifter carry when one exists.
// ----------------------------------------------------------------------------
module dpx_shifter import dpx_pkg::*; (
  input  logic [DataW-1:0]   value_in,
  input  logic [ShiftW-1:0]  shift_op,
  input  logic [AmountW-1:0] amount,
  input  logic               by_reg,
  input  logic               rrx_in,
  output dpx_shift_t         shift_o
);

  logic [4:0]         amt5;
  logic [4:0]         amt5_m1;
  logic [DataW-1:0]   lsl_val;
  logic [DataW-1:0]   lsl_pre;
  logic [DataW-1:0]   lsr_val;
  logic [DataW-1:0]   asr_val;
  logic [DataW-1:0]   rsh_pre;
  logic [2*DataW-1:0] ror_wide;
  logic [DataW-1:0]   fill;
  logic               sign;

  // Shift by the low five bits, amount assumed 1..31 here
  assign amt5     = amount[4:0];
  assign amt5_m1  = amt5 - 5'd1;
  assign sign     = value_in[DataW-1];
  assign fill     = {DataW{sign}};
  assign lsl_val  = value_in << amt5;
  assign lsl_pre  = value_in << amt5_m1;
  assign lsr_val  = value_in >> amt5;
  assign asr_val  = DataW'($signed(value_in) >>> amt5);
  assign rsh_pre  = value_in >> amt5_m1;
  assign ror_wide = {value_in, value_in} >> amt5;

  always_comb begin
    shift_o.has_carry = 1'b1;
    shift_o.carry     = 1'b0;
    shift_o.value     = value_in;

    if (!by_reg && amt5 == 5'd0) begin
      // Immediate amount zero: LSL #0, LSR #32, ASR #32, RRX
      case (shift_op)
        SHIFT_LSL: begin
          shift_o.has_carry = 1'b0;
        end
        SHIFT_LSR: begin
          shift_o.carry = sign;
          shift_o.value = '0;
        end
        SHIFT_ASR: begin
          shift_o.carry = sign;
          shift_o.value = fill;
        end
        default: begin
          shift_o.carry = value_in[0];
          shift_o.value = {rrx_in, value_in[DataW-1:1]};
        end
      endcase
    end else if (by_reg && amount == '0) begin
      // Register amount zero passes the operand and keeps C
      shift_o.has_carry = 1'b0;
    end else if (by_reg && shift_op == SHIFT_ROR && amt5 == 5'd0) begin
      // Rotate by a multiple of 32
      shift_o.carry = sign;
    end else if (by_reg && shift_op != SHIFT_ROR && amount[AmountW-1:5] != '0) begin
      // Register amount of 32 or more
      if (shift_op == SHIFT_ASR) begin
        shift_o.carry = sign;
        shift_o.value = fill;
      end else begin
        shift_o.value = '0;
        if (amount == AmountW'(DataW)) begin
          shift_o.carry = (shift_op == SHIFT_LSL) ? value_in[0] : sign;
        end
      end
    end else begin
      // Ordinary shift by 1..31
      case (shift_op)
        SHIFT_LSL: begin
          shift_o.carry = lsl_pre[DataW-1];
          shift_o.value = lsl_val;
        end
        SHIFT_LSR: begin
          shift_o.carry = rsh_pre[0];
          shift_o.value = lsr_val;
        end
        SHIFT_ASR: begin
          shift_o.carry = rsh_pre[0];
          shift_o.value = asr_val;
        end
        default: begin
          shift_o.carry = rsh_pre[0];
          shift_o.value = ror_wide[DataW-1:0];
        end
      endcase
    end
  end

endmodule

/* hw/rtl/dpx_alu.sv */
// ----------------------------------------------------------------------------
// Data-processing ALU
// Condition check, operand forming, logic/add/multiply operations and the
// NZCV update for one instruction against the current flags.
// ----------------------------------------------------------------------------
module dpx_alu import dpx_pkg::*; (
  input  dpx_item_t         item,
  input  logic [FlagsW-1:0] flags,
  output dpx_result_t       res
);

  dpx_shift_t       sh;
  logic             cond_ok;
  logic             act_ok;
  logic [DataW-1:0] op2;
  logic             op2_c;
  logic             op2_has_c;
  logic [DataW-1:0] rn;
  logic [DataW-1:0] add_a;
  logic [DataW-1:0] add_b;
  logic             add_cin;
  logic [DataW:0]   add_sum;
  logic [DataW-1:0] add_res;
  logic             add_v;
  logic [DataW-1:0] logic_res;
  logic [DataW-1:0] prod;
  logic [DataW-1:0] mac;
  logic             fn;
  logic             fz;
  logic             fc;
  logic             fv;

  assign fn = flags[FLAG_N];
  assign fz = flags[FLAG_Z];
  assign fc = flags[FLAG_C];
  assign fv = flags[FLAG_V];
  assign rn = item.first_operand;

  dpx_shifter u_shifter (
    .value_in (item.second_operand),
    .shift_op (item.shift_op),
    .amount   (item.shift_cnt),
    .by_reg   (item.shift_by_register),
    .rrx_in   (fc),
    .shift_o  (sh)
  );

  // Decode the condition code against the current flags
  always_comb begin
    unique case (cond_t'(item.cond))
      COND_EQ: cond_ok = fz;
      COND_NE: cond_ok = !fz;
      COND_CS: cond_ok = fc;
      COND_CC: cond_ok = !fc;
      COND_MI: cond_ok = fn;
      COND_PL: cond_ok = !fn;
      COND_VS: cond_ok = fv;
      COND_VC: cond_ok = !fv;
      COND_HI: cond_ok = fc && !fz;
      COND_LS: cond_ok = !fc || fz;
      COND_GE: cond_ok = (fn == fv);
      COND_LT: cond_ok = (fn != fv);
      COND_GT: cond_ok = !fz && (fn == fv);
      COND_LE: cond_ok = fz || (fn != fv);
      COND_AL: cond_ok = 1'b1;
      default: cond_ok = 1'b0;
    endcase
  end

  assign act_ok = (item.action <= ACT_MLA);

  // Pick the immediate or the shifted register as second operand
  assign op2       = item.is_immediate ? item.second_operand : sh.value;
  assign op2_c     = item.is_immediate ? item.second_operand[DataW-1] : sh.carry;
  assign op2_has_c = item.is_immediate ? item.imm_rotated : sh.has_carry;

  // Logic unit
  always_comb begin
    case (action_t'(item.action)) inside
      ACT_MOV:          logic_res = op2;
      ACT_MVN:          logic_res = ~op2;
      ACT_AND, ACT_TST: logic_res = rn & op2;
      ACT_EOR, ACT_TEQ: logic_res = rn ^ op2;
      ACT_ORR:          logic_res = rn | op2;
      default:          logic_res = rn & ~op2;
    endcase
  end

  // Adder operand select
  always_comb begin
    case (action_t'(item.action))
      ACT_ADD: begin
        add_a   = item.align_first ? {rn[DataW-1:2], 2'b00} : rn;
        add_b   = op2;
        add_cin = 1'b0;
      end
      ACT_CMN: begin
        add_a   = rn;
        add_b   = op2;
        add_cin = 1'b0;
      end
      ACT_ADC: begin
        add_a   = rn;
        add_b   = op2;
        add_cin = fc;
      end
      ACT_RSB: begin
        add_a   = op2;
        add_b   = ~rn;
        add_cin = 1'b1;
      end
      ACT_SBC: begin
        add_a   = rn;
        add_b   = ~op2;
        add_cin = fc;
      end
      ACT_RSC: begin
        add_a   = op2;
        add_b   = ~rn;
        add_cin = fc;
      end
      default: begin
        add_a   = rn;
        add_b   = ~op2;
        add_cin = 1'b1;
      end
    endcase
  end

  assign add_sum = {1'b0, add_a} + {1'b0, add_b} + {{DataW{1'b0}}, add_cin};
  assign add_res = add_sum[DataW-1:0];
  assign add_v   = ~(add_a[DataW-1] ^ add_b[DataW-1]) & (add_a[DataW-1] ^ add_res[DataW-1]);

  // Multiply, low word only
  assign prod = item.second_operand * item.multiplier;
  assign mac  = (item.action == ACT_MLA) ? prod + rn : prod;

  // Select the result and the flag update
  always_comb begin
    res.executed     = 1'b0;
    res.write_result = 1'b0;
    res.result_value = '0;
    res.flags_after  = flags;

    if (cond_ok && act_ok) begin
      res.executed     = 1'b1;
      res.write_result = 1'b1;
      case (action_t'(item.action)) inside
        ACT_MOV, ACT_MVN, ACT_AND, ACT_EOR, ACT_ORR, ACT_BIC, ACT_TST, ACT_TEQ: begin
          res.result_value = logic_res;
          if (item.action == ACT_TST || item.action == ACT_TEQ) begin
            res.write_result = 1'b0;
          end
          if (item.set_cc || item.action == ACT_TST || item.action == ACT_TEQ) begin
            res.flags_after[FLAG_N] = logic_res[DataW-1];
            res.flags_after[FLAG_Z] = (logic_res == '0);
            res.flags_after[FLAG_C] = op2_has_c ? op2_c : fc;
          end
        end
        ACT_MUL, ACT_MLA: begin
          res.result_value = mac;
          if (item.set_cc) begin
            res.flags_after[FLAG_N] = mac[DataW-1];
            res.flags_after[FLAG_Z] = (mac == '0);
          end
        end
        default: begin
          res.result_value = add_res;
          if (item.action == ACT_CMN || item.action == ACT_CMP) begin
            res.write_result = 1'b0;
          end
          if (item.set_cc || item.action == ACT_CMN || item.action == ACT_CMP) begin
            res.flags_after[FLAG_N] = add_res[DataW-1];
            res.flags_after[FLAG_Z] = (add_res == '0);
            res.flags_after[FLAG_C] = add_sum[DataW];
            res.flags_after[FLAG_V] = add_v;
          end
        end
      endcase
    end
  end

endmodule

/* hw/rtl/arm_data_processing_execute.sv */
// ----------------------------------------------------------------------------
// Data-processing execute stage
// Input register, one pass through shifter/ALU/multiplier, result register.
// ----------------------------------------------------------------------------
// An item waits in the input register; its result is then registered.
// Throughput: one instruction per cycle unless stalled; NZCV is written as an
// instruction leaves the input register, so the next one sees the new flags.
// Reset clears NZCV and both valid flags; payload registers are not reset.
module arm_data_processing_execute import dpx_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  dpx_in_if.sink    in_ch,
  dpx_out_if.source out_ch
);

  dpx_item_t         in_item;
  dpx_item_t         item_r;
  dpx_item_t         item_nxt;
  logic              item_vld_r;
  logic              item_vld_nxt;
  dpx_result_t       alu_res;
  dpx_result_t       res_r;
  dpx_result_t       res_nxt;
  logic              res_vld_r;
  logic              res_vld_nxt;
  logic [FlagsW-1:0] flags_r;
  logic [FlagsW-1:0] flags_nxt;
  logic              in_take;
  logic              advance;

  // Gather the incoming item
  assign in_item.action            = in_ch.action;
  assign in_item.cond              = in_ch.cond;
  assign in_item.set_cc            = in_ch.set_cc;
  assign in_item.first_operand     = in_ch.first_operand;
  assign in_item.second_operand    = in_ch.second_operand;
  assign in_item.is_immediate      = in_ch.is_immediate;
  assign in_item.imm_rotated       = in_ch.imm_rotated;
  assign in_item.shift_op          = in_ch.shift_op;
  assign in_item.shift_cnt         = in_ch.shift_cnt;
  assign in_item.shift_by_register = in_ch.shift_by_register;
  assign in_item.multiplier        = in_ch.multiplier;
  assign in_item.align_first       = in_ch.align_first;

  // Advance the held item when the result register is free or draining
  assign advance     = item_vld_r && (!res_vld_r || out_ch.ready);
  assign in_ch.ready = !item_vld_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;

  dpx_alu u_alu (
    .item  (item_r),
    .flags (flags_r),
    .res   (alu_res)
  );

  // Next-state for input register, result register and flags
  always_comb begin
    item_nxt     = in_take ? in_item : item_r;
    item_vld_nxt = in_take ? 1'b1 : (advance ? 1'b0 : item_vld_r);
    res_nxt      = advance ? alu_res : res_r;
    res_vld_nxt  = advance ? 1'b1 : (out_ch.ready ? 1'b0 : res_vld_r);
    flags_nxt    = advance ? alu_res.flags_after : flags_r;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      res_vld_r  <= 1'b0;
      flags_r    <= '0;
    end else begin
      item_vld_r <= item_vld_nxt;
      res_vld_r  <= res_vld_nxt;
      flags_r    <= flags_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r  <= res_nxt;
  end

  // Drive the result channel
  assign out_ch.valid        = res_vld_r;
  assign out_ch.executed     = res_r.executed;
  assign out_ch.write_result = res_r.write_result;
  assign out_ch.result_value = res_r.result_value;
  assign out_ch.flags_after  = res_r.flags_after;

endmodule
